// ===== sv/crt_pkg.sv =====
// ----------------------------------------------------------------------------
// crt_pkg
// Shared types, character codes and helpers for the CSV record tokenizer.
// ----------------------------------------------------------------------------
package crt_pkg;

  localparam logic [7:0]  CH_QUOTE = 8'h22;
  localparam logic [7:0]  CH_LF    = 8'h0A;
  localparam logic [7:0]  CH_CR    = 8'h0D;

  localparam logic [7:0]  DELIM_RESET      = 8'h2C;
  localparam logic [14:0] MAX_FIELDS_RESET = 15'd2000;

  localparam int unsigned FIELD_W = 15;

  typedef enum logic [2:0] {
    ST_START  = 3'd0,
    ST_PLAIN  = 3'd1,
    ST_QUOTED = 3'd2,
    ST_QSEEN  = 3'd3,
    ST_AFTERQ = 3'd4
  } parse_state_t;

  typedef enum logic [1:0] {
    ERR_NONE     = 2'd0,
    ERR_UNCLOSED = 2'd1,
    ERR_TOO_MANY = 2'd2
  } err_code_t;

  typedef enum logic {
    REG_DELIMITER  = 1'b0,
    REG_MAX_FIELDS = 1'b1
  } reg_index_t;

  typedef struct packed {
    logic [7:0]         data_byte;
    logic               data_valid;
    logic               field_end;
    logic               record_end;
    logic [FIELD_W-1:0] field_index;
    err_code_t          error_code;
    logic               last_of_run;
  } res_t;

  function automatic res_t make_res(input logic [7:0] byte_val, input logic valid,
                                    input logic fe, input logic re,
                                    input logic [FIELD_W-1:0] idx,
                                    input err_code_t code);
    res_t r;
    r.data_byte   = valid ? byte_val : 8'h00;
    r.data_valid  = valid;
    r.field_end   = fe;
    r.record_end  = re;
    r.field_index = idx;
    r.error_code  = code;
    r.last_of_run = 1'b0;
    return r;
  endfunction

endpackage

// ===== sv/crt_if.sv =====
// ----------------------------------------------------------------------------
// crt_if
// Valid/ready stream interfaces for the tokenizer's byte input and results.
// ----------------------------------------------------------------------------
interface crt_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       end_of_input;

  modport source (output valid, output in_byte, output end_of_input, input ready);
  modport sink (input valid, input in_byte, input end_of_input, output ready);
endinterface

interface crt_out_if;
  logic                        valid;
  logic                        ready;
  logic [7:0]                  data_byte;
  logic                        data_valid;
  logic                        field_end;
  logic                        record_end;
  logic [crt_pkg::FIELD_W-1:0] field_index;
  logic [1:0]                  error_code;
  logic                        last_of_run;

  modport source (output valid, output data_byte, output data_valid, output field_end,
                  output record_end, output field_index, output error_code,
                  output last_of_run, input ready);
  modport sink (input valid, input data_byte, input data_valid, input field_end,
                input record_end, input field_index, input error_code,
                input last_of_run, output ready);
endinterface

// ===== sv/csv_record_tokenizer.sv =====
// ----------------------------------------------------------------------------
// csv_record_tokenizer
// Splits a CSV byte stream into unescaped field bytes with field and record
// end marks, field index and error reporting.
// ----------------------------------------------------------------------------
// The tokenizer takes one byte per cycle into an input register and resolves
// it combinationally into at most two transactions, which wait in a two-entry
// result register for the output port. Most bytes give zero or one transaction
// and stream at one byte per cycle while the output port is ready; a byte after
// a pending carriage return that turns into data can give two transactions and
// holds the input until the second moves up, since the output port moves one
// transaction per cycle. Configuration must be written through the APB port
// only while the stream is idle; the block itself does not enforce this.
module csv_record_tokenizer (
  input  logic        clk,
  input  logic        rst_n,
  crt_in_if.sink      in_chan,
  crt_out_if.source   out_chan,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int unsigned FW = crt_pkg::FIELD_W;

  logic [7:0]            delim_r;
  logic [FW-1:0]         maxf_r;
  logic                  in_v_r;
  logic [7:0]            in_byte_r;
  logic                  eoi_r;
  crt_pkg::parse_state_t state_r, state_nxt;
  logic                  crp_r, crp_nxt;
  logic [FW-1:0]         fc_r, fc_nxt;
  logic                  err_r, err_nxt;
  crt_pkg::res_t         p0_r, p1_r;
  logic                  p0_v_r, p1_v_r;
  crt_pkg::res_t         r0, r1, hr;
  logic [1:0]            nres;
  logic                  hv;
  logic                  proc;
  logic                  load_ok;
  logic                  out_fire;
  logic                  cfg_wr;

  // Configuration port.
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_comb begin
    unique case (crt_pkg::reg_index_t'(paddr[2]))
      crt_pkg::REG_DELIMITER:  prdata = {24'd0, delim_r};
      crt_pkg::REG_MAX_FIELDS: prdata = {{(32-FW){1'b0}}, maxf_r};
      default:                 prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      delim_r <= crt_pkg::DELIM_RESET;
      maxf_r  <= crt_pkg::MAX_FIELDS_RESET;
    end else if (cfg_wr) begin
      unique case (crt_pkg::reg_index_t'(paddr[2]))
        crt_pkg::REG_DELIMITER:  delim_r <= pwdata[7:0];
        crt_pkg::REG_MAX_FIELDS: maxf_r  <= pwdata[FW-1:0];
        default:                 delim_r <= delim_r;
      endcase
    end
  end

  // Handshakes.
  assign out_fire      = p0_v_r && out_chan.ready;
  assign load_ok       = !p0_v_r || (out_chan.ready && !p1_v_r);
  assign proc          = in_v_r && load_ok;
  assign in_chan.ready = !in_v_r || proc;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else if (in_chan.ready) begin
      in_v_r <= in_chan.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_chan.valid && in_chan.ready) begin
      in_byte_r <= in_chan.in_byte;
      eoi_r     <= in_chan.end_of_input;
    end
  end

  // Tokenizer step for the registered byte.
  always_comb begin
    crt_pkg::parse_state_t s;
    logic                  handle;
    logic                  common;

    state_nxt = state_r;
    crp_nxt   = crp_r;
    fc_nxt    = fc_r;
    err_nxt   = err_r;
    r0        = '0;
    r1        = '0;
    hr        = '0;
    hv        = 1'b0;
    nres      = 2'd0;
    s         = state_r;
    handle    = 1'b0;
    common    = 1'b0;

    if (eoi_r) begin
      if (!err_r) begin
        priority if (crp_r) begin
          r0   = crt_pkg::make_res(8'h00, 1'b0, 1'b1, 1'b1, fc_r, crt_pkg::ERR_NONE);
          nres = 2'd1;
        end else if (state_r == crt_pkg::ST_QUOTED) begin
          r0   = crt_pkg::make_res(8'h00, 1'b0, 1'b0, 1'b0, fc_r, crt_pkg::ERR_UNCLOSED);
          nres = 2'd1;
        end else if (!(state_r == crt_pkg::ST_START && fc_r == '0)) begin
          r0   = crt_pkg::make_res(8'h00, 1'b0, 1'b1, 1'b1, fc_r, crt_pkg::ERR_NONE);
          nres = 2'd1;
        end else begin
          nres = 2'd0;
        end
      end
      state_nxt = crt_pkg::ST_START;
      crp_nxt   = 1'b0;
      fc_nxt    = '0;
      err_nxt   = 1'b0;
    end else if (!err_r) begin
      handle = 1'b1;
      if (crp_r) begin
        crp_nxt = 1'b0;
        if (in_byte_r == crt_pkg::CH_LF) begin
          r0        = crt_pkg::make_res(8'h00, 1'b0, 1'b1, 1'b1, fc_r, crt_pkg::ERR_NONE);
          nres      = 2'd1;
          fc_nxt    = '0;
          state_nxt = crt_pkg::ST_START;
          handle    = 1'b0;
        end else if (state_r != crt_pkg::ST_AFTERQ) begin
          r0   = crt_pkg::make_res(crt_pkg::CH_CR, 1'b1, 1'b0, 1'b0, fc_r,
                                   crt_pkg::ERR_NONE);
          nres = 2'd1;
          s    = crt_pkg::ST_PLAIN;
        end
      end

      if (handle) begin
        state_nxt = s;
        unique case (s)
          crt_pkg::ST_QUOTED: begin
            if (in_byte_r == crt_pkg::CH_QUOTE) begin
              state_nxt = crt_pkg::ST_QSEEN;
            end else begin
              hr = crt_pkg::make_res(in_byte_r, 1'b1, 1'b0, 1'b0, fc_r, crt_pkg::ERR_NONE);
              hv = 1'b1;
            end
          end
          crt_pkg::ST_QSEEN: begin
            if (in_byte_r == crt_pkg::CH_QUOTE) begin
              hr = crt_pkg::make_res(in_byte_r, 1'b1, 1'b0, 1'b0, fc_r, crt_pkg::ERR_NONE);
              hv = 1'b1;
              state_nxt = crt_pkg::ST_QUOTED;
            end else begin
              s         = crt_pkg::ST_AFTERQ;
              state_nxt = crt_pkg::ST_AFTERQ;
              common    = 1'b1;
            end
          end
          crt_pkg::ST_START, crt_pkg::ST_PLAIN, crt_pkg::ST_AFTERQ: common = 1'b1;
          default: begin
            s         = crt_pkg::ST_START;
            state_nxt = crt_pkg::ST_START;
            common    = 1'b1;
          end
        endcase

        if (common) begin
          priority if (s == crt_pkg::ST_START && in_byte_r == crt_pkg::CH_QUOTE) begin
            state_nxt = crt_pkg::ST_QUOTED;
          end else if (in_byte_r == crt_pkg::CH_LF) begin
            hr        = crt_pkg::make_res(8'h00, 1'b0, 1'b1, 1'b1, fc_r, crt_pkg::ERR_NONE);
            hv        = 1'b1;
            fc_nxt    = '0;
            state_nxt = crt_pkg::ST_START;
            crp_nxt   = 1'b0;
          end else if (in_byte_r == crt_pkg::CH_CR) begin
            crp_nxt = 1'b1;
          end else if (in_byte_r == delim_r) begin
            hv = 1'b1;
            if (({1'b0, fc_r} + (FW+1)'(1)) >= {1'b0, maxf_r}) begin
              hr      = crt_pkg::make_res(8'h00, 1'b0, 1'b1, 1'b0, fc_r,
                                          crt_pkg::ERR_TOO_MANY);
              err_nxt = 1'b1;
            end else begin
              hr        = crt_pkg::make_res(8'h00, 1'b0, 1'b1, 1'b0, fc_r,
                                            crt_pkg::ERR_NONE);
              fc_nxt    = fc_r + FW'(1);
              state_nxt = crt_pkg::ST_START;
            end
          end else if (s != crt_pkg::ST_AFTERQ) begin
            hr        = crt_pkg::make_res(in_byte_r, 1'b1, 1'b0, 1'b0, fc_r,
                                          crt_pkg::ERR_NONE);
            hv        = 1'b1;
            state_nxt = crt_pkg::ST_PLAIN;
          end else begin
            hv = 1'b0;
          end
        end
      end

      if (hv) begin
        if (nres == 2'd0) begin
          r0   = hr;
          nres = 2'd1;
        end else begin
          r1   = hr;
          nres = 2'd2;
        end
      end
    end

    if (nres == 2'd2) begin
      r1.last_of_run = 1'b1;
    end else if (nres == 2'd1) begin
      r0.last_of_run = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= crt_pkg::ST_START;
      crp_r   <= 1'b0;
      fc_r    <= '0;
      err_r   <= 1'b0;
    end else if (proc) begin
      state_r <= state_nxt;
      crp_r   <= crp_nxt;
      fc_r    <= fc_nxt;
      err_r   <= err_nxt;
    end
  end

  // Two-entry result register; p0 is the head shown on the output port.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p0_v_r <= 1'b0;
      p1_v_r <= 1'b0;
    end else if (proc) begin
      p0_v_r <= (nres != 2'd0);
      p1_v_r <= (nres == 2'd2);
    end else if (out_fire) begin
      p0_v_r <= p1_v_r;
      p1_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (proc) begin
      p0_r <= r0;
      p1_r <= r1;
    end else if (out_fire && p1_v_r) begin
      p0_r <= p1_r;
    end
  end

  assign out_chan.valid       = p0_v_r;
  assign out_chan.data_byte   = p0_r.data_byte;
  assign out_chan.data_valid  = p0_r.data_valid;
  assign out_chan.field_end   = p0_r.field_end;
  assign out_chan.record_end  = p0_r.record_end;
  assign out_chan.field_index = p0_r.field_index;
  assign out_chan.error_code  = p0_r.error_code;
  assign out_chan.last_of_run = p0_r.last_of_run;

  a_pair_order: assert property (@(posedge clk) disable iff (!rst_n)
    p1_v_r |-> p0_v_r)
    else $error("Second result entry is valid while the head is empty.");

  a_err_silent: assert property (@(posedge clk) disable iff (!rst_n)
    proc && err_r && !eoi_r |-> nres == 2'd0)
    else $error("A byte after a latched error produced a transaction.");

  a_rec_has_field: assert property (@(posedge clk) disable iff (!rst_n)
    out_chan.valid && out_chan.record_end |-> out_chan.field_end)
    else $error("Record end without field end.");

  a_err_from_proc: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(err_r) |-> $past(proc))
    else $error("Error latched without a processed byte.");

endmodule

// ===== tb/tb_csv_record_tokenizer.sv =====
// ----------------------------------------------------------------------------
// tb_csv_record_tokenizer
// Drives CSV text into the tokenizer and checks every result transaction
// against a short table or a cycle-free model of the parser. The table
// covers line ends, quoting, pending carriage returns, end of input and
// both error codes. Random records with quoted and plain fields follow over
// varied delimiters and field limits, under bursty input and output stalls.
// ----------------------------------------------------------------------------
module tb_csv_record_tokenizer;
  timeunit 1ns;
  timeprecision 1ps;

  import crt_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 600000;
  localparam int unsigned ITEMS_PER_PHASE = 160;
  localparam int unsigned NUM_PHASES = 10;
  localparam int unsigned SETTLE_CYCLES = 10;

  typedef struct {
    logic [7:0] b;
    logic       eoi;
    bit         typed;
    int         ntok;
    res_t       t0;
    res_t       t1;
  } item_t;

  typedef enum {ROW_ITEM, ROW_CFG} row_kind_t;

  typedef struct {
    row_kind_t   kind;
    reg_index_t  ridx;
    logic [14:0] val;
    item_t       it;
  } dir_row_t;

  logic        clk;
  logic        rst_n;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  crt_in_if  in_chan();
  crt_out_if out_chan();

  csv_record_tokenizer DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  // Parser state mirrored by the predictor.
  parse_state_t ps;
  logic         crp;
  logic [14:0]  fcnt;
  logic         elat;
  logic [7:0]   delim;
  logic [14:0]  maxf;

  res_t        fresh_tokens[$];
  res_t        expected_tokens[$];
  item_t       inflight[$];
  dir_row_t    dir_rows[$];
  int unsigned live_items;
  int unsigned burst_left;
  int unsigned cycles;
  int          mismatches;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic void emit_tok(logic [7:0] b, logic v, logic fe, logic re,
                                   err_code_t code);
    res_t r;
    r.data_byte   = v ? b : 8'h00;
    r.data_valid  = v;
    r.field_end   = fe;
    r.record_end  = re;
    r.field_index = fcnt;
    r.error_code  = code;
    r.last_of_run = 1'b0;
    fresh_tokens.push_back(r);
  endfunction

  function automatic void close_record();
    emit_tok(8'h00, 1'b0, 1'b1, 1'b1, ERR_NONE);
    fcnt = '0;
    ps   = ST_START;
    crp  = 1'b0;
  endfunction

  function automatic void close_field();
    if (int'(fcnt) + 1 >= int'(maxf)) begin
      emit_tok(8'h00, 1'b0, 1'b1, 1'b0, ERR_TOO_MANY);
      elat = 1'b1;
    end else begin
      emit_tok(8'h00, 1'b0, 1'b1, 1'b0, ERR_NONE);
      fcnt = fcnt + 15'd1;
      ps   = ST_START;
    end
  endfunction

  function automatic void scan_byte(logic [7:0] b);
    parse_state_t s;
    s = ps;
    if (s == ST_QUOTED) begin
      if (b == CH_QUOTE) ps = ST_QSEEN;
      else emit_tok(b, 1'b1, 1'b0, 1'b0, ERR_NONE);
      return;
    end
    if (s == ST_QSEEN) begin
      if (b == CH_QUOTE) begin
        emit_tok(b, 1'b1, 1'b0, 1'b0, ERR_NONE);
        ps = ST_QUOTED;
        return;
      end
      s  = ST_AFTERQ;
      ps = ST_AFTERQ;
    end
    if (s == ST_START && b == CH_QUOTE) begin
      ps = ST_QUOTED;
      return;
    end
    if (b == CH_LF) begin
      close_record();
    end else if (b == CH_CR) begin
      ps  = s;
      crp = 1'b1;
    end else if (b == delim) begin
      close_field();
    end else if (s != ST_AFTERQ) begin
      emit_tok(b, 1'b1, 1'b0, 1'b0, ERR_NONE);
      ps = ST_PLAIN;
    end
  endfunction

  function automatic void clear_parser();
    ps   = ST_START;
    crp  = 1'b0;
    fcnt = '0;
    elat = 1'b0;
  endfunction

  function automatic void tokenize_step(logic [7:0] b, logic eoi);
    bit   skip;
    res_t r;
    skip = 1'b0;
    fresh_tokens.delete();
    if (eoi) begin
      if (!elat) begin
        if (crp) close_record();
        else if (ps == ST_QUOTED) emit_tok(8'h00, 1'b0, 1'b0, 1'b0, ERR_UNCLOSED);
        else if (!(ps == ST_START && fcnt == 0)) close_record();
      end
      clear_parser();
    end else if (!elat) begin
      if (crp) begin
        crp = 1'b0;
        if (b == CH_LF) begin
          close_record();
          skip = 1'b1;
        end else if (ps != ST_AFTERQ) begin
          emit_tok(CH_CR, 1'b1, 1'b0, 1'b0, ERR_NONE);
          ps = ST_PLAIN;
        end
      end
      if (!skip) scan_byte(b);
    end
    if (fresh_tokens.size() > 0) begin
      r = fresh_tokens[fresh_tokens.size()-1];
      r.last_of_run = 1'b1;
      fresh_tokens[fresh_tokens.size()-1] = r;
    end
  endfunction

  task automatic check_fld(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected 0x%0h, actual 0x%0h", name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    item_t note;
    res_t  w;
    if (rst_n && in_chan.valid && in_chan.ready) begin
      note = inflight.pop_front();
      live_items++;
      tokenize_step(in_chan.in_byte, in_chan.end_of_input);
      if (note.typed) begin
        for (int k = 0; k < note.ntok; k++)
          expected_tokens.push_back(k == 0 ? note.t0 : note.t1);
      end else begin
        foreach (fresh_tokens[k]) expected_tokens.push_back(fresh_tokens[k]);
      end
    end
    if (rst_n && out_chan.valid && out_chan.ready) begin
      if (expected_tokens.size() == 0) begin
        $error("transaction with no expectation: byte 0x%0h field %0d code %0d",
               out_chan.data_byte, out_chan.field_index, out_chan.error_code);
        mismatches++;
      end else begin
        w = expected_tokens.pop_front();
        check_fld("data_byte", 32'(w.data_byte), 32'(out_chan.data_byte));
        check_fld("data_valid", 32'(w.data_valid), 32'(out_chan.data_valid));
        check_fld("field_end", 32'(w.field_end), 32'(out_chan.field_end));
        check_fld("record_end", 32'(w.record_end), 32'(out_chan.record_end));
        check_fld("field_index", 32'(w.field_index), 32'(out_chan.field_index));
        check_fld("error_code", 32'(w.error_code), 32'(out_chan.error_code));
        check_fld("last_of_run", 32'(w.last_of_run), 32'(out_chan.last_of_run));
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  initial begin
    int unsigned mode;
    int unsigned span;
    int unsigned tick;
    out_chan.ready = 1'b0;
    forever begin
      mode = $urandom_range(0, 3);
      span = $urandom_range(64, 400);
      for (tick = 0; tick < span; tick++) begin
        @(posedge clk);
        case (mode)
          0:       out_chan.ready <= 1'b1;
          1:       out_chan.ready <= ($urandom_range(0, 3) != 0);
          2:       out_chan.ready <= ($urandom_range(0, 3) == 0);
          default: out_chan.ready <= ((tick % 5) >= 2);
        endcase
      end
    end
  end

  task automatic send_item(item_t it);
    if (burst_left == 0) begin
      in_chan.valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
      burst_left = ($urandom_range(0, 9) == 0) ? 200 : $urandom_range(1, 16);
    end
    burst_left--;
    inflight.push_back(it);
    in_chan.valid        <= 1'b1;
    in_chan.in_byte      <= it.b;
    in_chan.end_of_input <= it.eoi;
    do @(posedge clk); while (!in_chan.ready);
  endtask

  task automatic send_raw(logic [7:0] b, logic eoi);
    item_t it;
    it.b     = b;
    it.eoi   = eoi;
    it.typed = 1'b0;
    it.ntok  = 0;
    it.t0    = '0;
    it.t1    = '0;
    send_item(it);
  endtask

  task automatic drain_stream();
    in_chan.valid <= 1'b0;
    while (inflight.size() != 0 || expected_tokens.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic cfg_write(reg_index_t r, logic [14:0] v);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {r, 2'b00};
    pwdata  <= 32'(v);
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (r == REG_DELIMITER) delim = v[7:0];
    else maxf = v;
    @(posedge clk);
  endtask

  function automatic logic [7:0] text_byte();
    if ($urandom_range(0, 4) == 0) return 8'($urandom_range(0, 255));
    return 8'("a" + $urandom_range(0, 25));
  endfunction

  task automatic gen_record();
    int unsigned nf;
    int unsigned len;
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 10) begin
      len = $urandom_range(1, 8);
      repeat (len) send_raw(8'($urandom_range(0, 255)), 1'b0);
    end else begin
      nf = $urandom_range(1, 5);
      for (int f = 0; f < nf; f++) begin
        if (f > 0) send_raw(delim, 1'b0);
        if ($urandom_range(0, 2) == 0) begin
          send_raw(CH_QUOTE, 1'b0);
          len = $urandom_range(0, 5);
          repeat (len) begin
            r = $urandom_range(0, 99);
            if (r < 50) send_raw(text_byte(), 1'b0);
            else if (r < 62) send_raw(delim, 1'b0);
            else if (r < 74) send_raw(CH_CR, 1'b0);
            else if (r < 82) send_raw(CH_LF, 1'b0);
            else begin
              send_raw(CH_QUOTE, 1'b0);
              send_raw(CH_QUOTE, 1'b0);
            end
          end
          if ($urandom_range(0, 9) != 0) begin
            send_raw(CH_QUOTE, 1'b0);
            if ($urandom_range(0, 7) == 0) send_raw(text_byte(), 1'b0);
          end
        end else begin
          len = $urandom_range(0, 6);
          repeat (len) send_raw(text_byte(), 1'b0);
        end
      end
      r = $urandom_range(0, 99);
      if (r < 45) begin
        send_raw(CH_LF, 1'b0);
      end else if (r < 75) begin
        send_raw(CH_CR, 1'b0);
        send_raw(CH_LF, 1'b0);
      end else if (r < 85) begin
        send_raw(8'($urandom_range(0, 255)), 1'b1);
      end else if (r < 93) begin
        send_raw(CH_CR, 1'b0);
      end
    end
    if ($urandom_range(0, 5) == 0) send_raw(8'($urandom_range(0, 255)), 1'b1);
  endtask

  function automatic res_t tok(logic [7:0] b, logic v, logic fe, logic re,
                               logic [14:0] idx, err_code_t code, logic last);
    res_t r;
    r.data_byte   = b;
    r.data_valid  = v;
    r.field_end   = fe;
    r.record_end  = re;
    r.field_index = idx;
    r.error_code  = code;
    r.last_of_run = last;
    return r;
  endfunction

  function automatic dir_row_t byte_row(logic [7:0] b, logic eoi, int n,
                                        res_t t0 = '0, res_t t1 = '0);
    dir_row_t d;
    d.kind     = ROW_ITEM;
    d.ridx     = REG_DELIMITER;
    d.val      = '0;
    d.it.b     = b;
    d.it.eoi   = eoi;
    d.it.typed = 1'b1;
    d.it.ntok  = n;
    d.it.t0    = t0;
    d.it.t1    = t1;
    return d;
  endfunction

  function automatic dir_row_t cfg_row(reg_index_t r, logic [14:0] v);
    dir_row_t d;
    d = byte_row(8'h00, 1'b0, 0);
    d.kind = ROW_CFG;
    d.ridx = r;
    d.val  = v;
    return d;
  endfunction

  initial begin
    logic [7:0]  d;
    logic [14:0] m;
    int unsigned goal;
    in_chan.valid        = 1'b0;
    in_chan.in_byte      = 8'h00;
    in_chan.end_of_input = 1'b0;
    psel       = 1'b0;
    penable    = 1'b0;
    pwrite     = 1'b0;
    paddr      = '0;
    pwdata     = '0;
    rst_n      = 1'b0;
    delim      = DELIM_RESET;
    maxf       = MAX_FIELDS_RESET;
    live_items = 0;
    burst_left = 0;
    cycles     = 0;
    mismatches = 0;
    clear_parser();

    dir_rows.push_back(byte_row("a", 1'b0, 1, tok("a", 1, 0, 0, 0, ERR_NONE, 1)));
    dir_rows.push_back(byte_row(",", 1'b0, 1, tok(0, 0, 1, 0, 0, ERR_NONE, 1)));
    dir_rows.push_back(byte_row(CH_QUOTE, 1'b0, 0));
    dir_rows.push_back(byte_row(",", 1'b0, 1, tok(",", 1, 0, 0, 1, ERR_NONE, 1)));
    dir_rows.push_back(byte_row(CH_QUOTE, 1'b0, 0));
    dir_rows.push_back(byte_row(CH_QUOTE, 1'b0, 1, tok(CH_QUOTE, 1, 0, 0, 1, ERR_NONE, 1)));
    dir_rows.push_back(byte_row(CH_LF, 1'b0, 1, tok(CH_LF, 1, 0, 0, 1, ERR_NONE, 1)));
    dir_rows.push_back(byte_row(CH_QUOTE, 1'b0, 0));
    dir_rows.push_back(byte_row("x", 1'b0, 0));
    dir_rows.push_back(byte_row(CH_CR, 1'b0, 0));
    dir_rows.push_back(byte_row(CH_LF, 1'b0, 1, tok(0, 0, 1, 1, 1, ERR_NONE, 1)));
    dir_rows.push_back(byte_row(CH_CR, 1'b0, 0));
    dir_rows.push_back(byte_row(CH_QUOTE, 1'b0, 2, tok(CH_CR, 1, 0, 0, 0, ERR_NONE, 0),
                                tok(CH_QUOTE, 1, 0, 0, 0, ERR_NONE, 1)));
    dir_rows.push_back(byte_row(8'hFF, 1'b0, 1, tok(8'hFF, 1, 0, 0, 0, ERR_NONE, 1)));
    dir_rows.push_back(byte_row(CH_CR, 1'b0, 0));
    dir_rows.push_back(byte_row(8'hAA, 1'b1, 1, tok(0, 0, 1, 1, 0, ERR_NONE, 1)));
    dir_rows.push_back(byte_row(CH_QUOTE, 1'b0, 0));
    dir_rows.push_back(byte_row(8'h55, 1'b1, 1, tok(0, 0, 0, 0, 0, ERR_UNCLOSED, 1)));
    dir_rows.push_back(cfg_row(REG_MAX_FIELDS, 15'd1));
    dir_rows.push_back(byte_row(",", 1'b0, 1, tok(0, 0, 1, 0, 0, ERR_TOO_MANY, 1)));
    dir_rows.push_back(byte_row("z", 1'b0, 0));
    dir_rows.push_back(byte_row(8'h00, 1'b1, 0));
    dir_rows.push_back(cfg_row(REG_MAX_FIELDS, MAX_FIELDS_RESET));

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_rows[i]) begin
      if (dir_rows[i].kind == ROW_CFG) begin
        drain_stream();
        cfg_write(dir_rows[i].ridx, dir_rows[i].val);
      end else begin
        send_item(dir_rows[i].it);
      end
    end

    goal = live_items;
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      case (ph)
        0: begin d = DELIM_RESET; m = MAX_FIELDS_RESET; end
        1: begin d = 8'h00; m = 15'd3; end
        2: begin d = 8'hFF; m = 15'h7FFF; end
        3: begin d = CH_QUOTE; m = 15'd4; end
        4: begin d = CH_CR; m = 15'd5; end
        5: begin d = CH_LF; m = 15'd2; end
        6: begin d = ";"; m = 15'd1; end
        7: begin d = 8'h09; m = 15'($urandom_range(1, 8)); end
        8: begin d = 8'($urandom_range(0, 255)); m = 15'($urandom_range(1, 32767)); end
        default: begin d = DELIM_RESET; m = 15'd3; end
      endcase
      drain_stream();
      cfg_write(REG_DELIMITER, 15'(d));
      cfg_write(REG_MAX_FIELDS, m);
      goal += ITEMS_PER_PHASE;
      while (live_items < goal) gen_record();
    end

    drain_stream();
    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
